### rtl/ceb_pkg.sv
// Shared types and constants for the clause exchange buffer parser.
// No dependencies; every other file of the block refers to this package.
package ceb_pkg;

  localparam int WORD_W  = 32;
  localparam int CNT_W   = 17;
  localparam int SZ_W    = 11;

  localparam int BUFFER_WORDS_DEF   = 65536;
  localparam int MAX_CLAUSE_LEN_DEF = 1024;

  // Hardware limits of the count and size registers.
  localparam int CNT_LIMIT = 131071;
  localparam int SZ_LIMIT  = 2047;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_VIP   = 4'b0010,
    PH_SIZED = 4'b0100,
    PH_ERROR = 4'b1000
  } phase_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] word;
    logic                     first_word;
  } item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] literal;
    logic [SZ_W-1:0]          clause_size;
    logic                     is_vip;
    logic                     clause_last;
    logic                     parse_error;
  } result_t;

endpackage

### rtl/ceb_in_if.sv
// Input channel of the clause exchange buffer parser: one buffer word per transfer.
// Depends on ceb_pkg for the word width.
interface ceb_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [ceb_pkg::WORD_W-1:0] word;
  logic                              first_word;

  modport source (output valid, output word, output first_word, input ready);
  modport sink   (input valid, input word, input first_word, output ready);
endinterface

### rtl/ceb_out_if.sv
// Result channel of the clause exchange buffer parser: one literal per transfer.
// Depends on ceb_pkg for the field widths.
interface ceb_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ceb_pkg::WORD_W-1:0] literal;
  logic [ceb_pkg::SZ_W-1:0]          clause_size;
  logic                              is_vip;
  logic                              clause_last;
  logic                              parse_error;

  modport source (output valid, output literal, output clause_size, output is_vip,
                  output clause_last, output parse_error, input ready);
  modport sink   (input valid, input literal, input clause_size, input is_vip,
                  input clause_last, input parse_error, output ready);
endinterface

### rtl/clause_exchange_buffer_parser.sv
// Top level of the clause exchange buffer parser.
// Depends on ceb_pkg, ceb_in_if, ceb_out_if, ceb_in_reg, ceb_parser and ceb_out_reg.
//
// The block reads a shared-clause buffer one 32-bit word per transfer and gives
// one literal per transfer on the result side. A word flagged first_word is the
// header: it holds the number of VIP words, separators included, and restarts
// parsing from any state. VIP clauses follow, each ended by a zero word; the
// last VIP word always closes the open clause. Then for clause sizes 1, 2, 3 and
// so on comes a count word followed by that many clauses of that size. Every
// literal carries its clause size, a VIP mark and a last-of-clause mark; for VIP
// literals the size is given only on the last literal of the clause. One VIP
// literal is held back until the next word shows whether its clause ends, so a
// VIP literal appears one word later than it arrives. A negative count word puts
// the block in a sticky error state in which every following word yields a
// result with parse_error set and all other fields zero, until the next header.
// Counts saturate at min(BUFFER_WORDS-1, 131071), sizes at min(MAX_CLAUSE_LEN,
// 2047). Throughput is one word per clock cycle with no gaps while the result
// side accepts; a word passes through one input register and one result
// register, with the per-word counter update between them. Words that yield no
// result (headers, count words, separators) still pass the input register. A
// stalled result side holds the input side only once both registers are full.
module clause_exchange_buffer_parser #(
  parameter int BUFFER_WORDS   = ceb_pkg::BUFFER_WORDS_DEF,
  parameter int MAX_CLAUSE_LEN = ceb_pkg::MAX_CLAUSE_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ceb_in_if.sink    in_ch,
  ceb_out_if.source out_ch
);

  ceb_pkg::item_t   in_item;
  ceb_pkg::item_t   item;
  logic             item_valid;
  logic             take;
  logic             res_valid;
  ceb_pkg::result_t res;
  ceb_pkg::result_t out_res;

  assign in_item.word       = in_ch.word;
  assign in_item.first_word = in_ch.first_word;

  ceb_in_reg u_in_reg (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_item         (in_item),
    .downstream_take (take),
    .item_valid      (item_valid),
    .item            (item)
  );

  // The parsing state steps exactly when the registered word is finished.
  ceb_parser #(
    .BUFFER_WORDS   (BUFFER_WORDS),
    .MAX_CLAUSE_LEN (MAX_CLAUSE_LEN)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (item_valid && take),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  ceb_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .res_valid  (res_valid),
    .res        (res),
    .take       (take),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_res    (out_res)
  );

  assign out_ch.literal     = out_res.literal;
  assign out_ch.clause_size = out_res.clause_size;
  assign out_ch.is_vip      = out_res.is_vip;
  assign out_ch.clause_last = out_res.clause_last;
  assign out_ch.parse_error = out_res.parse_error;

endmodule

### rtl/ceb_in_reg.sv
// Input register stage of the clause exchange buffer parser.
// Depends on ceb_pkg for the item type.
module ceb_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ceb_pkg::item_t  in_item,
  input  logic            downstream_take,
  output logic            item_valid,
  output ceb_pkg::item_t  item
);

  logic           valid_r, valid_nxt;
  ceb_pkg::item_t item_r;

  // The stage is free when empty or when its word moves on this cycle.
  assign in_ready = !valid_r || downstream_take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

### rtl/ceb_parser.sv
// Parsing state and per-word step logic of the clause exchange buffer parser.
// Depends on ceb_pkg for the phase, item and result types.
module ceb_parser #(
  parameter int BUFFER_WORDS   = ceb_pkg::BUFFER_WORDS_DEF,
  parameter int MAX_CLAUSE_LEN = ceb_pkg::MAX_CLAUSE_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  ceb_pkg::item_t   item,
  output logic             res_valid,
  output ceb_pkg::result_t res
);

  localparam int WORD_W = ceb_pkg::WORD_W;
  localparam int CNT_W  = ceb_pkg::CNT_W;
  localparam int SZ_W   = ceb_pkg::SZ_W;
  localparam int CNT_CAP_I = (BUFFER_WORDS - 1 > ceb_pkg::CNT_LIMIT) ?
                             ceb_pkg::CNT_LIMIT : BUFFER_WORDS - 1;
  localparam int SZ_CAP_I  = (MAX_CLAUSE_LEN > ceb_pkg::SZ_LIMIT) ?
                             ceb_pkg::SZ_LIMIT : MAX_CLAUSE_LEN;
  localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(CNT_CAP_I);
  localparam logic [SZ_W-1:0]  SIZE_CAP  = SZ_W'(SZ_CAP_I);

  ceb_pkg::phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]           vip_words_left_r, vip_words_left_nxt;
  logic [SZ_W-1:0]            size_class_r, size_class_nxt;
  logic [CNT_W-1:0]           clauses_left_r, clauses_left_nxt;
  logic [SZ_W-1:0]            literals_left_r, literals_left_nxt;
  logic [SZ_W-1:0]            vip_length_r, vip_length_nxt;
  logic signed [WORD_W-1:0]   held_literal_r, held_literal_nxt;
  logic                       held_valid_r, held_valid_nxt;

  logic [CNT_W-1:0]           word_count;
  logic [CNT_W-1:0]           vip_dec;
  logic [CNT_W-1:0]           clause_dec;
  logic [SZ_W-1:0]            size_inc;

  // Negative words count as zero, large ones saturate.
  function automatic logic [CNT_W-1:0] clamp_count(input logic [WORD_W-1:0] w);
    logic [CNT_W-1:0] c;
    if (w[WORD_W-1]) begin
      c = '0;
    end else if (w > WORD_W'(COUNT_CAP)) begin
      c = COUNT_CAP;
    end else begin
      c = w[CNT_W-1:0];
    end
    return c;
  endfunction

  function automatic logic [SZ_W-1:0] inc_size(input logic [SZ_W-1:0] s);
    return (s >= SIZE_CAP) ? SIZE_CAP : s + SZ_W'(1);
  endfunction

  assign word_count = clamp_count(item.word);
  assign vip_dec    = vip_words_left_r - CNT_W'(1);
  assign clause_dec = clauses_left_r - CNT_W'(1);
  assign size_inc   = inc_size(size_class_r);

  always_comb begin
    phase_nxt          = phase_r;
    vip_words_left_nxt = vip_words_left_r;
    size_class_nxt     = size_class_r;
    clauses_left_nxt   = clauses_left_r;
    literals_left_nxt  = literals_left_r;
    vip_length_nxt     = vip_length_r;
    held_literal_nxt   = held_literal_r;
    held_valid_nxt     = held_valid_r;
    res_valid          = 1'b0;
    res                = '0;

    if (item.first_word) begin
      // A header restarts the buffer from any phase.
      vip_words_left_nxt = word_count;
      size_class_nxt     = '0;
      clauses_left_nxt   = '0;
      literals_left_nxt  = '0;
      vip_length_nxt     = '0;
      held_literal_nxt   = '0;
      held_valid_nxt     = 1'b0;
      phase_nxt          = (word_count != '0) ? ceb_pkg::PH_VIP : ceb_pkg::PH_SIZED;
    end else begin
      unique case (phase_r)
        ceb_pkg::PH_IDLE: begin
        end
        ceb_pkg::PH_ERROR: begin
          res_valid       = 1'b1;
          res.parse_error = 1'b1;
        end
        ceb_pkg::PH_VIP: begin
          vip_words_left_nxt = vip_dec;
          if (item.word != '0 && vip_dec != '0) begin
            // Release the previous literal; this one is held until we know
            // whether the clause ends after it.
            res_valid        = held_valid_r;
            res.literal      = held_literal_r;
            res.is_vip       = 1'b1;
            held_literal_nxt = item.word;
            held_valid_nxt   = 1'b1;
            vip_length_nxt   = inc_size(vip_length_r);
          end else begin
            // Separator, or the final VIP word, closes the open clause.
            res_valid        = held_valid_r;
            res.literal      = held_literal_r;
            res.clause_size  = vip_length_r;
            res.is_vip       = 1'b1;
            res.clause_last  = 1'b1;
            held_literal_nxt = '0;
            held_valid_nxt   = 1'b0;
            vip_length_nxt   = '0;
          end
          if (vip_dec == '0) begin
            phase_nxt = ceb_pkg::PH_SIZED;
          end
        end
        ceb_pkg::PH_SIZED: begin
          if (clauses_left_r == '0) begin
            // Count word for the next size class.
            size_class_nxt = size_inc;
            if (item.word[WORD_W-1]) begin
              phase_nxt       = ceb_pkg::PH_ERROR;
              res_valid       = 1'b1;
              res.parse_error = 1'b1;
            end else begin
              clauses_left_nxt  = word_count;
              literals_left_nxt = (word_count != '0) ? size_inc : '0;
            end
          end else begin
            res_valid       = 1'b1;
            res.literal     = item.word;
            res.clause_size = size_class_r;
            res.clause_last = (literals_left_r <= SZ_W'(1));
            if (literals_left_r <= SZ_W'(1)) begin
              clauses_left_nxt  = clause_dec;
              literals_left_nxt = (clause_dec != '0) ? size_class_r : '0;
            end else begin
              literals_left_nxt = literals_left_r - SZ_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= ceb_pkg::PH_IDLE;
      vip_words_left_r <= '0;
      size_class_r     <= '0;
      clauses_left_r   <= '0;
      literals_left_r  <= '0;
      vip_length_r     <= '0;
      held_literal_r   <= '0;
      held_valid_r     <= 1'b0;
    end else if (advance) begin
      phase_r          <= phase_nxt;
      vip_words_left_r <= vip_words_left_nxt;
      size_class_r     <= size_class_nxt;
      clauses_left_r   <= clauses_left_nxt;
      literals_left_r  <= literals_left_nxt;
      vip_length_r     <= vip_length_nxt;
      held_literal_r   <= held_literal_nxt;
      held_valid_r     <= held_valid_nxt;
    end
  end

  a_header_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    advance && item.first_word |=> phase_r != ceb_pkg::PH_IDLE)
    else $error("header did not start a buffer");

  a_held_only_in_vip: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid_r |-> phase_r == ceb_pkg::PH_VIP)
    else $error("held literal outside the VIP region");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !item.first_word && phase_r == ceb_pkg::PH_ERROR
    |-> res_valid && res.parse_error && phase_nxt == ceb_pkg::PH_ERROR)
    else $error("error phase did not report an error");

  a_sized_counters_agree: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == ceb_pkg::PH_SIZED |-> (clauses_left_r == '0) == (literals_left_r == '0))
    else $error("clause and literal counters disagree");

endmodule

### rtl/ceb_out_reg.sv
// Result register of the clause exchange buffer parser.
// Depends on ceb_pkg for the result type.
module ceb_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  input  logic             res_valid,
  input  ceb_pkg::result_t res,
  output logic             take,
  output logic             out_valid,
  input  logic             out_ready,
  output ceb_pkg::result_t out_res
);

  logic             valid_r, valid_nxt;
  ceb_pkg::result_t res_r;

  // A word can be finished whenever the result slot is empty or drains now.
  assign take = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r && !out_ready;
    if (item_valid && take) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && take && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
